// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the unmasker core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define WSU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define WSU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/wsu_pkg.sv
// ----------------------------------------------------------------------------
// wsu_pkg
// Types and constants for the frame unmasker.
// ----------------------------------------------------------------------------
package wsu_pkg;

  localparam logic [7:0] HDR_TEXT  = 8'h81;  // FIN + text opcode
  localparam logic [7:0] LEN_MASK  = 8'h7f;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_LEN    = 4'd1,
    PH_EXT_HI = 4'd2,
    PH_EXT_LO = 4'd3,
    PH_MASK0  = 4'd4,
    PH_MASK1  = 4'd5,
    PH_MASK2  = 4'd6,
    PH_MASK3  = 4'd7,
    PH_DATA   = 4'd8
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_start;
  } item_t;

endpackage

// File: design/wsu_in_if.sv
// ----------------------------------------------------------------------------
// wsu_in_if
// Raw byte channel into the unmasker.
// ----------------------------------------------------------------------------
interface wsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_start;

  modport source (output valid, output in_byte, output frame_start, input ready);
  modport sink   (input valid, input in_byte, input frame_start, output ready);
endinterface

// File: design/wsu_out_if.sv
// ----------------------------------------------------------------------------
// wsu_out_if
// Unmasked payload channel out of the unmasker.
// ----------------------------------------------------------------------------
interface wsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic       last_byte;

  modport source (output valid, output plain_byte, output last_byte, input ready);
  modport sink   (input valid, input plain_byte, input last_byte, output ready);
endinterface

// File: design/wsu_in_stage.sv
// ----------------------------------------------------------------------------
// wsu_in_stage
// Input register: holds one received item until the core takes it.
// ----------------------------------------------------------------------------
module wsu_in_stage (
  input  logic           clk,
  input  logic           rst,
  wsu_in_if.sink         in_ch,
  input  logic           take,
  output logic           item_vld,
  output wsu_pkg::item_t item
);

  logic           vld;
  wsu_pkg::item_t held;

  // Refill in the same cycle the held item is taken.
  assign in_ch.ready = !vld || take;
  assign item_vld    = vld;
  assign item        = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ch.ready) begin
      vld <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      held.in_byte     <= in_ch.in_byte;
      held.frame_start <= in_ch.frame_start;
    end
  end

endmodule

// File: design/wsu_unmask_core.sv
// ----------------------------------------------------------------------------
// wsu_unmask_core
// Frame parser state, XOR unmasking and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsu_unmask_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_vld,
  input  wsu_pkg::item_t item,
  output logic           take,
  wsu_out_if.source      out_ch
);

  wsu_pkg::phase_t phase, phase_next;
  logic [31:0]     mask_key, mask_key_next;
  logic [15:0]     bytes_left, bytes_left_next;
  logic [1:0]      mask_index, mask_index_next;

  logic            emit;
  logic            last;
  logic [7:0]      mask_byte;
  logic [6:0]      len_code;

  logic            out_vld;
  logic [7:0]      plain_byte;
  logic            last_byte;

  assign take     = item_vld && (!out_vld || out_ch.ready);
  assign len_code = 7'(item.in_byte & wsu_pkg::LEN_MASK);
  assign last     = (bytes_left <= 16'd1);

  always_comb begin
    unique case (mask_index)
      2'd0: mask_byte = mask_key[31:24];
      2'd1: mask_byte = mask_key[23:16];
      2'd2: mask_byte = mask_key[15:8];
      2'd3: mask_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next      = phase;
    mask_key_next   = mask_key;
    bytes_left_next = bytes_left;
    mask_index_next = mask_index;
    emit            = 1'b0;
    if (item.frame_start) begin
      phase_next      = (item.in_byte == wsu_pkg::HDR_TEXT) ? wsu_pkg::PH_LEN
                                                            : wsu_pkg::PH_IDLE;
      mask_key_next   = '0;
      bytes_left_next = '0;
      mask_index_next = '0;
    end else begin
      unique case (phase)
        wsu_pkg::PH_LEN: begin
          priority if (len_code == wsu_pkg::LEN_EXT16) begin
            phase_next = wsu_pkg::PH_EXT_HI;
          end else if (len_code == wsu_pkg::LEN_EXT64) begin
            phase_next = wsu_pkg::PH_IDLE;
          end else begin
            bytes_left_next = {9'd0, len_code};
            phase_next      = wsu_pkg::PH_MASK0;
          end
        end
        wsu_pkg::PH_EXT_HI: begin
          bytes_left_next = {item.in_byte, 8'd0};
          phase_next      = wsu_pkg::PH_EXT_LO;
        end
        wsu_pkg::PH_EXT_LO: begin
          bytes_left_next = {bytes_left[15:8], item.in_byte};
          phase_next      = wsu_pkg::PH_MASK0;
        end
        wsu_pkg::PH_MASK0, wsu_pkg::PH_MASK1, wsu_pkg::PH_MASK2: begin
          mask_key_next = {mask_key[23:0], item.in_byte};
          phase_next    = wsu_pkg::phase_t'(phase + 4'd1);
        end
        wsu_pkg::PH_MASK3: begin
          mask_key_next   = {mask_key[23:0], item.in_byte};
          mask_index_next = '0;
          phase_next      = (bytes_left == 16'd0) ? wsu_pkg::PH_IDLE
                                                  : wsu_pkg::PH_DATA;
        end
        wsu_pkg::PH_DATA: begin
          emit            = 1'b1;
          mask_index_next = mask_index + 2'd1;
          if (last) begin
            bytes_left_next = '0;
            phase_next      = wsu_pkg::PH_IDLE;
          end else begin
            bytes_left_next = bytes_left - 16'd1;
          end
        end
        default: begin
          // idle and unused codes: byte is dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= wsu_pkg::PH_IDLE;
      mask_key   <= '0;
      bytes_left <= '0;
      mask_index <= '0;
    end else if (take) begin
      phase      <= phase_next;
      mask_key   <= mask_key_next;
      bytes_left <= bytes_left_next;
      mask_index <= mask_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (take && emit) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      plain_byte <= item.in_byte ^ mask_byte;
      last_byte  <= last;
    end
  end

  assign out_ch.valid      = out_vld;
  assign out_ch.plain_byte = plain_byte;
  assign out_ch.last_byte  = last_byte;

  `WSU_ASSERT_ALWAYS(a_reset_clears, rst |=> (!out_vld && phase == wsu_pkg::PH_IDLE), "reset did not clear state")
  `WSU_ASSERT(a_data_nonzero, phase == wsu_pkg::PH_DATA |-> bytes_left != 16'd0, "payload phase with nothing left")
  `WSU_ASSERT(a_last_to_idle, take && emit && last |=> phase == wsu_pkg::PH_IDLE, "last byte did not end frame")
  `WSU_ASSERT(a_index_step, take && emit |=> mask_index == 2'($past(mask_index) + 2'd1), "mask index did not advance")

endmodule

// File: design/websocket_frame_unmasker.sv
// ----------------------------------------------------------------------------
// websocket_frame_unmasker
// Parses client frames byte by byte and emits the unmasked text payload.
// ----------------------------------------------------------------------------
// Input channel in_ch carries one received byte per item, frame_start
// flagging the first byte of a frame. Only the 0x81 header is taken; the
// 7-bit or 16-bit length and the four mask bytes follow, then each payload
// byte leaves on out_ch XORed with its mask byte, last_byte set on the final
// one. Rejected frames and stray bytes produce no item.
// Throughput: one byte per cycle, sustained while out_ch is ready. The parser
// state update is combinational logic between the input register and the
// result register. A payload byte passes through the input register and then
// the result register before it is presented on out_ch.
// Reset (rst, synchronous) empties both registers and returns the parser to
// waiting for a header.
// When out_ch stalls, the result register holds its item and the input
// register can still take one more byte; further input then waits.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker (
  input  logic      clk,
  input  logic      rst,
  wsu_in_if.sink    in_ch,
  wsu_out_if.source out_ch
);

  logic           take;
  logic           item_vld;
  wsu_pkg::item_t item;

  wsu_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .take     (take),
    .item_vld (item_vld),
    .item     (item)
  );

  wsu_unmask_core u_core (
    .clk      (clk),
    .rst      (rst),
    .item_vld (item_vld),
    .item     (item),
    .take     (take),
    .out_ch   (out_ch)
  );

endmodule
